// ----- hw/rtl/stp_pkg.sv -----
// ----------------------------------------------------------------------------
// stp_pkg: shared types and constants of the stepper pulse generator
// Field widths, request kinds, stream layouts and divider interface structs.
// ----------------------------------------------------------------------------
package stp_pkg;

    localparam int COUNT_BITS  = 24;
    localparam int PERIOD_BITS = 16;
    localparam int KIND_BITS   = 3;

    // Product of a period and a step count, divided down by a step count.
    localparam int PROD_BITS     = COUNT_BITS + PERIOD_BITS;
    localparam int DIV_CNT_BITS  = (PERIOD_BITS > 1) ? $clog2(PERIOD_BITS) : 1;

    // Input stream: total, accel, decel, min period, first period.
    localparam int IN_FIELD_BITS = 3 * COUNT_BITS + 2 * PERIOD_BITS;
    localparam int IN_DATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int IN_PAD_BITS   = IN_DATA_BITS - IN_FIELD_BITS;
    localparam int USER_BITS     = 8;

    // Output stream: level, event, busy, done, loaded period.
    localparam int OUT_FIELD_BITS = 4 + PERIOD_BITS;
    localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_BITS   = OUT_DATA_BITS - OUT_FIELD_BITS;

    localparam logic [KIND_BITS-1:0] KIND_TICK   = 3'd0;
    localparam logic [KIND_BITS-1:0] KIND_START  = 3'd1;
    localparam logic [KIND_BITS-1:0] KIND_PAUSE  = 3'd2;
    localparam logic [KIND_BITS-1:0] KIND_RESUME = 3'd3;
    localparam logic [KIND_BITS-1:0] KIND_STOP   = 3'd4;

    typedef struct packed {
        logic                   start;
        logic [PERIOD_BITS-1:0] base;
        logic [COUNT_BITS-1:0]  num;
        logic [COUNT_BITS-1:0]  den;
    } div_req_t;

    typedef struct packed {
        logic                   busy;
        logic                   done;
        logic [PERIOD_BITS-1:0] quo;
    } div_rsp_t;

endpackage

// ----- hw/rtl/stp_div.sv -----
// ----------------------------------------------------------------------------
// stp_div: shared multiply and serial divide unit
// Computes floor(base * num / den) for num < den, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module stp_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  stp_pkg::div_req_t req,
    output stp_pkg::div_rsp_t rsp
);
    import stp_pkg::*;

    typedef enum logic [2:0] {
        D_IDLE = 3'b001,
        D_LOAD = 3'b010,
        D_RUN  = 3'b100
    } div_state_t;

    div_state_t              state_reg, state_next;
    logic [PROD_BITS-1:0]    prod_reg, prod_next;
    logic [COUNT_BITS-1:0]   den_reg, den_next;
    logic [COUNT_BITS-1:0]   rem_reg, rem_next;
    logic [PERIOD_BITS-1:0]  quo_reg, quo_next;
    logic [DIV_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                    done_reg, done_next;
    logic [COUNT_BITS:0]     shifted;
    logic [COUNT_BITS:0]     trial;

    // Since num < den the quotient fits in PERIOD_BITS and the upper part of
    // the product is already below the divisor.
    assign shifted = {rem_reg, quo_reg[PERIOD_BITS-1]};
    assign trial   = shifted - {1'b0, den_reg};

    always_comb
    begin
        state_next = state_reg;
        prod_next  = prod_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        case (state_reg)
            D_IDLE:
            begin
                if (req.start)
                begin
                    prod_next  = PROD_BITS'(req.base) * PROD_BITS'(req.num);
                    den_next   = req.den;
                    state_next = D_LOAD;
                end
            end
            D_LOAD:
            begin
                rem_next   = prod_reg[PROD_BITS-1:PERIOD_BITS];
                quo_next   = prod_reg[PERIOD_BITS-1:0];
                cnt_next   = DIV_CNT_BITS'(PERIOD_BITS - 1);
                state_next = D_RUN;
            end
            D_RUN:
            begin
                if (!trial[COUNT_BITS])
                begin
                    rem_next = trial[COUNT_BITS-1:0];
                    quo_next = {quo_reg[PERIOD_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_next = shifted[COUNT_BITS-1:0];
                    quo_next = {quo_reg[PERIOD_BITS-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    done_next  = 1'b1;
                    state_next = D_IDLE;
                end
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
    end

    assign rsp.busy = (state_reg != D_IDLE);
    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

// ----- hw/rtl/stepper_trapezoid_pulse_gen_core.sv -----
// ----------------------------------------------------------------------------
// stepper_trapezoid_pulse_gen_core: single-axis trapezoidal step generator
// Sequencer and move state around a shared multiply and serial divide unit.
// ----------------------------------------------------------------------------
// Usage:
//   Each request on s_axis is a tick, a start, a pause, a resume or a stop,
//   selected by s_axis_tuser. Every request yields exactly one response on
//   m_axis with the step line level, a toggle flag, the busy flag, the move
//   done flag and the period now loaded.
//   After the edge that accepts a request, the block passes the execute
//   state and loads the response register in the output state. A tick that
//   toggles the line also passes the zone state, and in a ramp zone it waits
//   in the divide state for the multiply and bit-serial divide of the next
//   period. s_axis_tready is high only while no request is in work, so the
//   next request is taken at the earliest once the previous response is loaded.
//   The response sits in an output register, so the next request is taken
//   and worked on while the previous response waits; a stalled m_axis only
//   holds the block once a second response is ready.
//   Reset clears the move state: line low, idle, not halted, period zero.
// ----------------------------------------------------------------------------
module stepper_trapezoid_pulse_gen_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // total_steps, accel_count, decel_steps, min_period, first_period
    input  logic [stp_pkg::IN_DATA_BITS-1:0]    s_axis_tdata,
    // kind
    input  logic [stp_pkg::USER_BITS-1:0]       s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // step_level, step_event, busy_res, move_done, loaded_period
    output logic [stp_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata
);
    import stp_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_ZONE = 5'b00100,
        S_DIV  = 5'b01000,
        S_OUT  = 5'b10000
    } seq_state_t;

    seq_state_t               state_reg, state_next;
    logic [KIND_BITS-1:0]     kind_reg, kind_next;
    logic [COUNT_BITS-1:0]    tot_in_reg, tot_in_next;
    logic [COUNT_BITS-1:0]    acc_in_reg, acc_in_next;
    logic [COUNT_BITS-1:0]    dec_in_reg, dec_in_next;
    logic [PERIOD_BITS-1:0]   minp_in_reg, minp_in_next;
    logic [PERIOD_BITS-1:0]   firstp_in_reg, firstp_in_next;

    logic                     level_reg, level_next;
    logic [COUNT_BITS-1:0]    steps_done_reg, steps_done_next;
    logic [COUNT_BITS-1:0]    steps_total_reg, steps_total_next;
    logic [COUNT_BITS-1:0]    ramp_up_reg, ramp_up_next;
    logic [COUNT_BITS-1:0]    ramp_down_reg, ramp_down_next;
    logic [PERIOD_BITS-1:0]   cruise_reg, cruise_next;
    logic [PERIOD_BITS-1:0]   tick_reg, tick_next;
    logic                     active_reg, active_next;
    logic                     halted_reg, halted_next;
    logic [PERIOD_BITS-1:0]   period_reg, period_next;
    logic                     event_reg, event_next;
    logic                     done_reg, done_next;
    logic [COUNT_BITS-1:0]    dstart_reg, dstart_next;
    logic                     dn_ok_reg, dn_ok_next;
    logic                     out_valid_reg, out_valid_next;
    logic [OUT_DATA_BITS-1:0] out_data_reg, out_data_next;

    logic [COUNT_BITS:0]      zone_sum;
    logic                     cut;
    logic [COUNT_BITS-1:0]    acc_cut;
    logic                     up_hit;
    logic                     dn_hit;
    logic [PERIOD_BITS:0]     period_sum;

    div_req_t                 div_req;
    div_rsp_t                 div_rsp;

    stp_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Triangle cut when the two ramps do not fit inside the move.
    assign zone_sum = {1'b0, acc_in_reg} + {1'b0, dec_in_reg};
    assign cut      = (zone_sum >= {1'b0, tot_in_reg});
    assign acc_cut  = tot_in_reg >> 1;

    assign up_hit = (ramp_up_reg != '0) && (steps_done_reg <= ramp_up_reg);
    assign dn_hit = (ramp_down_reg != '0) && dn_ok_reg && (steps_done_reg >= dstart_reg);

    assign period_sum = {1'b0, cruise_reg} + {1'b0, div_rsp.quo};

    always_comb
    begin
        state_next       = state_reg;
        kind_next        = kind_reg;
        tot_in_next      = tot_in_reg;
        acc_in_next      = acc_in_reg;
        dec_in_next      = dec_in_reg;
        minp_in_next     = minp_in_reg;
        firstp_in_next   = firstp_in_reg;
        level_next       = level_reg;
        steps_done_next  = steps_done_reg;
        steps_total_next = steps_total_reg;
        ramp_up_next     = ramp_up_reg;
        ramp_down_next   = ramp_down_reg;
        cruise_next      = cruise_reg;
        tick_next        = tick_reg;
        active_next      = active_reg;
        halted_next      = halted_reg;
        period_next      = period_reg;
        event_next       = event_reg;
        done_next        = done_reg;
        dstart_next      = dstart_reg;
        dn_ok_next       = dn_ok_reg;
        out_valid_next   = out_valid_reg && !m_axis_tready;
        out_data_next    = out_data_reg;
        div_req.start    = 1'b0;
        div_req.base     = cruise_reg;
        div_req.num      = ramp_up_reg - steps_done_reg;
        div_req.den      = ramp_up_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    kind_next      = s_axis_tuser[KIND_BITS-1:0];
                    tot_in_next    = s_axis_tdata[COUNT_BITS-1:0];
                    acc_in_next    = s_axis_tdata[2*COUNT_BITS-1:COUNT_BITS];
                    dec_in_next    = s_axis_tdata[3*COUNT_BITS-1:2*COUNT_BITS];
                    minp_in_next   = s_axis_tdata[3*COUNT_BITS+PERIOD_BITS-1:3*COUNT_BITS];
                    firstp_in_next = s_axis_tdata[IN_FIELD_BITS-1:3*COUNT_BITS+PERIOD_BITS];
                    event_next     = 1'b0;
                    done_next      = 1'b0;
                    state_next     = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_OUT;
                case (kind_reg)
                    KIND_TICK:
                    begin
                        if (active_reg && !halted_reg)
                        begin
                            if (tick_reg >= period_reg)
                            begin
                                level_next      = ~level_reg;
                                event_next      = 1'b1;
                                tick_next       = '0;
                                steps_done_next = steps_done_reg + 1'b1;
                                dstart_next     = steps_total_reg - ramp_down_reg;
                                dn_ok_next      = (ramp_down_reg <= steps_total_reg);
                                state_next      = S_ZONE;
                            end
                            else
                            begin
                                tick_next = tick_reg + 1'b1;
                            end
                        end
                    end
                    KIND_START:
                    begin
                        if (!active_reg)
                        begin
                            if (cut)
                            begin
                                ramp_up_next   = acc_cut;
                                ramp_down_next = tot_in_reg - acc_cut;
                            end
                            else
                            begin
                                ramp_up_next   = acc_in_reg;
                                ramp_down_next = dec_in_reg;
                            end
                            halted_next      = 1'b0;
                            tick_next        = '0;
                            steps_done_next  = '0;
                            steps_total_next = tot_in_reg;
                            cruise_next      = minp_in_reg;
                            period_next      = firstp_in_reg;
                            if (tot_in_reg == '0)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                active_next = 1'b1;
                            end
                        end
                    end
                    KIND_PAUSE:
                    begin
                        halted_next = 1'b1;
                    end
                    KIND_RESUME:
                    begin
                        halted_next = 1'b0;
                    end
                    KIND_STOP:
                    begin
                        active_next = 1'b0;
                        halted_next = 1'b0;
                        tick_next   = '0;
                    end
                    default:
                    begin
                        state_next = S_OUT;
                    end
                endcase
            end
            S_ZONE:
            begin
                if (steps_done_reg < steps_total_reg)
                begin
                    if (up_hit)
                    begin
                        div_req.start = 1'b1;
                        state_next    = S_DIV;
                    end
                    else if (dn_hit)
                    begin
                        div_req.start = 1'b1;
                        div_req.num   = steps_done_reg - dstart_reg;
                        div_req.den   = ramp_down_reg;
                        state_next    = S_DIV;
                    end
                    else
                    begin
                        period_next = cruise_reg;
                        state_next  = S_OUT;
                    end
                end
                else
                begin
                    active_next = 1'b0;
                    done_next   = 1'b1;
                    state_next  = S_OUT;
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    if (period_sum[PERIOD_BITS])
                    begin
                        period_next = '1;
                    end
                    else
                    begin
                        period_next = period_sum[PERIOD_BITS-1:0];
                    end
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {{OUT_PAD_BITS{1'b0}}, period_reg, done_reg,
                                      active_reg, event_reg, level_reg};
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            level_reg       <= 1'b0;
            steps_done_reg  <= '0;
            steps_total_reg <= '0;
            ramp_up_reg     <= '0;
            ramp_down_reg   <= '0;
            cruise_reg      <= '0;
            tick_reg        <= '0;
            active_reg      <= 1'b0;
            halted_reg      <= 1'b0;
            period_reg      <= '0;
            event_reg       <= 1'b0;
            done_reg        <= 1'b0;
            dstart_reg      <= '0;
            dn_ok_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            level_reg       <= level_next;
            steps_done_reg  <= steps_done_next;
            steps_total_reg <= steps_total_next;
            ramp_up_reg     <= ramp_up_next;
            ramp_down_reg   <= ramp_down_next;
            cruise_reg      <= cruise_next;
            tick_reg        <= tick_next;
            active_reg      <= active_next;
            halted_reg      <= halted_next;
            period_reg      <= period_next;
            event_reg       <= event_next;
            done_reg        <= done_next;
            dstart_reg      <= dstart_next;
            dn_ok_reg       <= dn_ok_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        tot_in_reg    <= tot_in_next;
        acc_in_reg    <= acc_in_next;
        dec_in_reg    <= dec_in_next;
        minp_in_reg   <= minp_in_next;
        firstp_in_reg <= firstp_in_next;
        out_data_reg  <= out_data_next;
    end

`ifndef NO_ASSERTIONS
    // A finished move is never reported as still busy.
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[3] && m_axis_tdata[2]))
        else $error("response reports move done while still busy");

    // The tick counter never runs past the loaded period.
    a_tick_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        tick_reg <= period_reg)
        else $error("tick counter beyond loaded period");

    // The divider only finishes while the sequencer waits for it.
    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_DIV))
        else $error("divider finished outside the wait state");

    // The divider is never busy while new requests are taken.
    a_div_idle_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !div_rsp.busy)
        else $error("divider busy while the block accepts requests");
`endif

endmodule

// ----- verif/step_pulse_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// step_pulse_checker: response checker for the stepper pulse generator
// Follows every accepted request with its own copy of the move state, works
// out the response it must produce and compares each response leaving
// m_axis, field by field, with the oldest one still outstanding.
// ----------------------------------------------------------------------------
module step_pulse_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    input  logic                              s_axis_tready,
    // total_steps, accel_count, decel_steps, min_period, first_period
    input  logic [stp_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,
    // kind
    input  logic [stp_pkg::USER_BITS-1:0]     s_axis_tuser,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // step_level, step_event, busy_res, move_done, loaded_period
    input  logic [stp_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
    output int                                fail_count,
    output int                                pending
);

    import stp_pkg::*;

    typedef struct packed {
        logic [PERIOD_BITS-1:0] first_period;
        logic [PERIOD_BITS-1:0] min_period;
        logic [COUNT_BITS-1:0]  decel_steps;
        logic [COUNT_BITS-1:0]  accel_count;
        logic [COUNT_BITS-1:0]  total_steps;
    } move_cmd_t;

    typedef struct packed {
        logic [PERIOD_BITS-1:0] period;
        logic                   done;
        logic                   busy;
        logic                   toggled;
        logic                   level;
    } step_resp_t;

    logic                   line_level;
    logic [COUNT_BITS-1:0]  steps_done;
    logic [COUNT_BITS-1:0]  steps_total;
    logic [COUNT_BITS-1:0]  ramp_up_len;
    logic [COUNT_BITS-1:0]  ramp_down_len;
    logic [PERIOD_BITS-1:0] cruise_period;
    logic [PERIOD_BITS-1:0] tick_count;
    logic [PERIOD_BITS-1:0] held_period;
    logic                   moving;
    logic                   halted;

    step_resp_t expected_resp[$];

    // Period that follows step n: stretched in the two ramp zones, clamped
    // to the widest value the period register can hold.
    function automatic logic [PERIOD_BITS-1:0] ramp_period(logic [COUNT_BITS-1:0] n);
        logic [63:0] base;
        logic [63:0] left;
        logic [63:0] sum;
        base = 64'(cruise_period);
        sum  = base;
        if (ramp_up_len != '0 && n <= ramp_up_len)
        begin
            sum = base + (base * 64'(ramp_up_len - n)) / 64'(ramp_up_len);
        end
        else if (ramp_down_len != '0 && ramp_down_len <= steps_total &&
                 n >= steps_total - ramp_down_len)
        begin
            left = 64'(steps_total - n);
            sum  = base + (base * (64'(ramp_down_len) - left)) / 64'(ramp_down_len);
        end
        return (sum > 64'({PERIOD_BITS{1'b1}})) ? {PERIOD_BITS{1'b1}} : sum[PERIOD_BITS-1:0];
    endfunction

    task automatic predict_response(input logic [KIND_BITS-1:0] kind, input move_cmd_t cmd,
                                    output step_resp_t resp);
        logic [COUNT_BITS:0]   zone_sum;
        logic [COUNT_BITS-1:0] up_len;
        logic [COUNT_BITS-1:0] down_len;
        resp = '0;
        case (kind)
            KIND_TICK:
            begin
                if (moving && !halted)
                begin
                    if (tick_count >= held_period)
                    begin
                        line_level   = ~line_level;
                        resp.toggled = 1'b1;
                        tick_count   = '0;
                        steps_done   = steps_done + 1'b1;
                        if (steps_done < steps_total)
                        begin
                            held_period = ramp_period(steps_done);
                        end
                        else
                        begin
                            moving    = 1'b0;
                            resp.done = 1'b1;
                        end
                    end
                    else
                    begin
                        tick_count = tick_count + 1'b1;
                    end
                end
            end
            KIND_START:
            begin
                if (!moving)
                begin
                    up_len   = cmd.accel_count;
                    down_len = cmd.decel_steps;
                    zone_sum = {1'b0, up_len} + {1'b0, down_len};
                    // Zones that overlap are cut back to a triangle.
                    if (zone_sum >= {1'b0, cmd.total_steps})
                    begin
                        up_len   = cmd.total_steps >> 1;
                        down_len = cmd.total_steps - up_len;
                    end
                    halted        = 1'b0;
                    tick_count    = '0;
                    steps_done    = '0;
                    steps_total   = cmd.total_steps;
                    ramp_up_len   = up_len;
                    ramp_down_len = down_len;
                    cruise_period = cmd.min_period;
                    held_period   = cmd.first_period;
                    if (cmd.total_steps == '0)
                    begin
                        resp.done = 1'b1;
                    end
                    else
                    begin
                        moving = 1'b1;
                    end
                end
            end
            KIND_PAUSE:
            begin
                halted = 1'b1;
            end
            KIND_RESUME:
            begin
                halted = 1'b0;
            end
            KIND_STOP:
            begin
                moving     = 1'b0;
                halted     = 1'b0;
                tick_count = '0;
            end
            default:
            begin
            end
        endcase
        resp.level  = line_level;
        resp.busy   = moving;
        resp.period = held_period;
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        step_resp_t want;
        step_resp_t got;
        if (!rst_n)
        begin
            line_level    = 1'b0;
            steps_done    = '0;
            steps_total   = '0;
            ramp_up_len   = '0;
            ramp_down_len = '0;
            cruise_period = '0;
            tick_count    = '0;
            held_period   = '0;
            moving        = 1'b0;
            halted        = 1'b0;
            expected_resp.delete();
            fail_count    = 0;
            pending       = 0;
        end
        else
        begin
            // A response always trails its request through registers, so the
            // response side is settled before this edge's request is added.
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[OUT_FIELD_BITS-1:0];
                if (expected_resp.size() == 0)
                begin
                    $display("%0t: response 0x%0h with no request outstanding, expected none",
                             $time, got);
                    fail_count++;
                end
                else
                begin
                    want = expected_resp.pop_front();
                    check_field("step_level", 32'(want.level), 32'(got.level));
                    check_field("step_event", 32'(want.toggled), 32'(got.toggled));
                    check_field("busy_res", 32'(want.busy), 32'(got.busy));
                    check_field("move_done", 32'(want.done), 32'(got.done));
                    check_field("loaded_period", 32'(want.period), 32'(got.period));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_response(s_axis_tuser[KIND_BITS-1:0],
                                 move_cmd_t'(s_axis_tdata[IN_FIELD_BITS-1:0]), want);
                expected_resp.push_back(want);
            end
            pending = expected_resp.size();
        end
    end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the stepper pulse generator
// Drives a short directed list of requests, then random moves with ticks and
// some noise, through phases of sender gaps and receiver stalls. A separate
// checker predicts and compares every response.
// ----------------------------------------------------------------------------
module testbench;

    import stp_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 12;
    localparam int RANDOM_ITEMS  = 850;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 40;

    // Kinds the block has no use for; they must leave the state alone.
    localparam logic [KIND_BITS-1:0] KIND_SPARE_LO = 3'd5;
    localparam logic [KIND_BITS-1:0] KIND_SPARE_HI = 3'd7;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [IN_DATA_BITS-1:0]  s_axis_tdata = '0;
    logic [USER_BITS-1:0]     s_axis_tuser = '0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_axis_tdata;

    int fail_count;
    int pending;
    int sent_count = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;
    int idle_by_phase [4] = '{0, 58, 0, 22};
    int stall_by_phase [4] = '{0, 0, 58, 22};

    stepper_trapezoid_pulse_gen_core DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    step_pulse_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(negedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no request or response moved for %0d cycles", $time,
                         quiet_cycles);
                $display("TB_ERROR");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(input logic [KIND_BITS-1:0] kind,
                                input logic [COUNT_BITS-1:0] total_steps,
                                input logic [COUNT_BITS-1:0] accel_count,
                                input logic [COUNT_BITS-1:0] decel_steps,
                                input logic [PERIOD_BITS-1:0] min_period,
                                input logic [PERIOD_BITS-1:0] first_period);
        while ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = IN_DATA_BITS'({first_period, min_period, decel_steps, accel_count,
                                       total_steps});
        s_axis_tuser  = USER_BITS'(kind);
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        sent_count++;
    endtask

    // Random bits fill the move fields; every kind but a start ignores them.
    task automatic send_kind(input logic [KIND_BITS-1:0] kind);
        send_request(kind, COUNT_BITS'($urandom), COUNT_BITS'($urandom),
                     COUNT_BITS'($urandom), PERIOD_BITS'($urandom), PERIOD_BITS'($urandom));
    endtask

    task automatic wait_drained();
        s_axis_tvalid = 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
    endtask

    // A well-formed move followed by enough ticks to finish it, with the odd
    // pause, stray start, spare kind, stray resume or early stop mixed in.
    task automatic run_move();
        int unsigned total;
        int unsigned min_p;
        int unsigned first_p;
        int unsigned budget;
        int unsigned roll;
        int unsigned n;
        if ($urandom_range(9) == 0)
        begin
            total = $urandom_range(40, 13);
            min_p = $urandom_range(1);
        end
        else
        begin
            total = $urandom_range(12, 1);
            min_p = $urandom_range(3);
        end
        first_p = $urandom_range(3);
        send_request(KIND_START, COUNT_BITS'(total), COUNT_BITS'($urandom_range(6)),
                     COUNT_BITS'($urandom_range(6)), PERIOD_BITS'(min_p),
                     PERIOD_BITS'(first_p));
        budget = first_p + 1 + (total - 1) * (2 * min_p + 1);
        for (n = 0; n < budget; n++)
        begin
            roll = $urandom_range(99);
            if (roll < 3)
            begin
                send_kind(KIND_PAUSE);
                send_kind(KIND_TICK);
                send_kind(KIND_RESUME);
            end
            else if (roll < 5)
            begin
                send_request(KIND_START, COUNT_BITS'($urandom_range(12, 1)),
                             COUNT_BITS'($urandom_range(6)), COUNT_BITS'($urandom_range(6)),
                             PERIOD_BITS'($urandom_range(3)), PERIOD_BITS'($urandom_range(3)));
            end
            else if (roll < 6)
            begin
                send_kind(KIND_BITS'($urandom_range(KIND_SPARE_HI, KIND_SPARE_LO)));
            end
            else if (roll < 7)
            begin
                send_kind(KIND_RESUME);
            end
            else if (roll < 8 && $urandom_range(3) == 0)
            begin
                send_kind(KIND_STOP);
            end
            send_kind(KIND_TICK);
        end
        if ($urandom_range(1) == 1)
        begin
            send_kind(KIND_STOP);
        end
    endtask

    // Random kinds and full-range starts, always closed by a stop so the next
    // move is not blocked by a long one.
    task automatic run_noise();
        int unsigned count;
        int unsigned n;
        count = $urandom_range(6, 1);
        for (n = 0; n < count; n++)
        begin
            if ($urandom_range(2) == 0)
            begin
                send_request(KIND_START, COUNT_BITS'($urandom), COUNT_BITS'($urandom),
                             COUNT_BITS'($urandom), PERIOD_BITS'($urandom),
                             ($urandom_range(1) == 1) ? PERIOD_BITS'($urandom)
                                                      : PERIOD_BITS'($urandom_range(3)));
            end
            else
            begin
                send_kind(KIND_BITS'($urandom_range(7)));
            end
        end
        repeat ($urandom_range(8)) send_kind(KIND_TICK);
        send_kind(KIND_STOP);
    endtask

    initial
    begin
        int phase;
        int directed_end;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Requests while idle change nothing but the halted flag.
        send_kind(KIND_TICK);
        send_kind(KIND_PAUSE);
        send_kind(KIND_TICK);
        send_kind(KIND_RESUME);
        // A move of zero steps reports done at once.
        send_request(KIND_START, '0, '0, '0, '0, '0);
        send_kind(KIND_SPARE_LO);
        send_kind(KIND_BITS'(KIND_SPARE_LO + 3'd1));
        send_kind(KIND_SPARE_HI);
        // No ramp zones and zero periods: every tick steps.
        send_request(KIND_START, 24'd4, '0, '0, '0, '0);
        repeat (4) send_kind(KIND_TICK);
        // Overlapping zones and the widest cruise period saturate the ramp.
        send_request(KIND_START, 24'd6, 24'd3, 24'd3, '1, 16'd1);
        send_kind(KIND_TICK);
        send_kind(KIND_TICK);
        send_request(KIND_START, 24'd2, '0, '0, '0, '0);
        send_kind(KIND_PAUSE);
        send_kind(KIND_TICK);
        send_kind(KIND_RESUME);
        send_kind(KIND_STOP);
        // All fields but the first period at their top values.
        send_request(KIND_START, '1, '1, '1, '1, '0);
        send_kind(KIND_TICK);
        send_kind(KIND_STOP);

        wait_drained();
        directed_end = sent_count;

        for (phase = 0; phase < 4; phase++)
        begin
            idle_pct  = idle_by_phase[phase];
            stall_pct = stall_by_phase[phase];
            while (sent_count < directed_end + (phase + 1) * RANDOM_ITEMS / 4)
            begin
                if ($urandom_range(99) < 85)
                begin
                    run_move();
                end
                else
                begin
                    run_noise();
                end
            end
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
